@@ sv/assert_macros.svh @@
// assertion macros shared by the calculator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

@@ sv/atoc_pkg.sv @@
// types, constants and character helpers for the ascii calculator
package atoc_pkg;

  localparam int CHAR_W         = 8;
  localparam int VALUE_W        = 32;
  localparam int STATUS_W       = 2;
  localparam int MAX_DIGITS_DEF = 8;
  localparam int RADIX          = 10;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_OVERFLOW,
    ST_NO_OPERATOR,
    ST_DIV_ZERO
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDSUB,
    S_MUL,
    S_DIV,
    S_DONE
  } alu_state_t;

  // expression summary handed from the parser to the arithmetic unit
  typedef struct packed {
    logic ovf;
    logic op_seen;
    op_t  op;
  } launch_t;

  // bits needed for a number of the given digit count
  function automatic int acc_width(input int digits);
    return $clog2(RADIX ** digits);
  endfunction

  function automatic logic is_numeral(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_op(input logic [CHAR_W-1:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
  endfunction

  function automatic op_t op_code(input logic [CHAR_W-1:0] c);
    op_t op;
    unique case (c)
      CH_MINUS: op = OP_SUB;
      CH_STAR:  op = OP_MUL;
      CH_SLASH: op = OP_DIV;
      default:  op = OP_ADD;
    endcase
    return op;
  endfunction

endpackage

@@ sv/atoc_in_if.sv @@
// request channel carrying one expression character
interface atoc_in_if;
  logic                          valid;
  logic                          ready;
  logic [atoc_pkg::CHAR_W-1:0]   char_byte;
  logic                          final_char;

  modport source (output valid, output char_byte, output final_char, input ready);
  modport sink   (input valid, input char_byte, input final_char, output ready);
endinterface

@@ sv/atoc_out_if.sv @@
// result channel carrying value and status
interface atoc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [atoc_pkg::VALUE_W-1:0] value;
  logic [atoc_pkg::STATUS_W-1:0]       status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

@@ sv/atoc_parser.sv @@
// character front end: digit accumulation, operand and operator capture
`include "assert_macros.svh"
module atoc_parser #(
  parameter int MAX_NUMBER_DIGITS = atoc_pkg::MAX_DIGITS_DEF,
  localparam int ACC_W  = atoc_pkg::acc_width(MAX_NUMBER_DIGITS),
  localparam int DCNT_W = $clog2(MAX_NUMBER_DIGITS + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [atoc_pkg::CHAR_W-1:0] char_byte,
  input  logic                        final_char,
  output atoc_pkg::launch_t           launch,
  output logic [ACC_W-1:0]            first_opnd,
  output logic [ACC_W-1:0]            second_opnd
);

  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [1:0]        nseen_r, nseen_nxt;
  logic [ACC_W-1:0]  first_r, first_nxt;
  logic [ACC_W-1:0]  second_r, second_nxt;
  logic              opseen_r, opseen_nxt;
  atoc_pkg::op_t     opcode_r, opcode_nxt;
  logic              ovf_r, ovf_nxt;

  logic              digit_w, op_w, close_w;
  logic [3:0]        digit_val;
  logic [ACC_W+3:0]  times10;
  logic [ACC_W-1:0]  acc_dig;

  assign digit_w   = atoc_pkg::is_numeral(char_byte);
  assign op_w      = atoc_pkg::is_op(char_byte);
  assign close_w   = op_w || final_char;
  assign digit_val = 4'(char_byte - atoc_pkg::CH_ZERO);
  // acc * 10 + digit as two shifts and adds
  assign times10   = ((ACC_W+4)'(acc_r) << 3) + ((ACC_W+4)'(acc_r) << 1)
                   + (ACC_W+4)'(digit_val);
  assign acc_dig   = ACC_W'(times10);

  always_comb begin
    logic [ACC_W-1:0] acc_t;
    logic [ACC_W-1:0] first_t;
    logic [ACC_W-1:0] second_t;
    logic [1:0]       nseen_t;
    acc_t      = acc_r;
    dcnt_nxt   = dcnt_r;
    ovf_nxt    = ovf_r;
    opseen_nxt = opseen_r;
    opcode_nxt = opcode_r;
    if (digit_w) begin
      if (dcnt_r >= DCNT_W'(MAX_NUMBER_DIGITS)) begin
        ovf_nxt = 1'b1;
      end else begin
        acc_t    = acc_dig;
        dcnt_nxt = dcnt_r + 1'b1;
      end
    end
    if (op_w && !opseen_r) begin
      opseen_nxt = 1'b1;
      opcode_nxt = atoc_pkg::op_code(char_byte);
    end
    first_t  = first_r;
    second_t = second_r;
    nseen_t  = nseen_r;
    acc_nxt  = acc_t;
    if (close_w) begin
      if (nseen_r == 2'd0) begin
        first_t = acc_t;
        nseen_t = 2'd1;
      end else if (nseen_r == 2'd1) begin
        second_t = acc_t;
        nseen_t  = 2'd2;
      end
      acc_nxt  = '0;
      dcnt_nxt = '0;
    end
    first_nxt  = first_t;
    second_nxt = second_t;
    nseen_nxt  = nseen_t;

    launch.ovf     = ovf_nxt;
    launch.op_seen = opseen_nxt;
    launch.op      = opcode_nxt;
    first_opnd     = first_t;
    second_opnd    = second_t;

    // expression ends: everything returns to the reset value
    if (final_char) begin
      acc_nxt    = '0;
      dcnt_nxt   = '0;
      nseen_nxt  = '0;
      first_nxt  = '0;
      second_nxt = '0;
      opseen_nxt = 1'b0;
      opcode_nxt = atoc_pkg::OP_ADD;
      ovf_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      dcnt_r   <= '0;
      nseen_r  <= '0;
      first_r  <= '0;
      second_r <= '0;
      opseen_r <= 1'b0;
      opcode_r <= atoc_pkg::OP_ADD;
      ovf_r    <= 1'b0;
    end else if (fire) begin
      acc_r    <= acc_nxt;
      dcnt_r   <= dcnt_nxt;
      nseen_r  <= nseen_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      opseen_r <= opseen_nxt;
      opcode_r <= opcode_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  `ASSERT_NEXT(a_clear_after_final, clk, rst_n, fire && final_char, acc_r == '0 && nseen_r == 2'd0 && !ovf_r && !opseen_r)
  `ASSERT_IMPLY(a_dcnt_bound, clk, rst_n, 1'b1, dcnt_r <= DCNT_W'(MAX_NUMBER_DIGITS))

endmodule

@@ sv/atoc_alu.sv @@
// shared adder sequenced for add, subtract, shift-add multiply, restoring divide
`include "assert_macros.svh"
module atoc_alu #(
  parameter int MAX_NUMBER_DIGITS = atoc_pkg::MAX_DIGITS_DEF,
  localparam int ACC_W = atoc_pkg::acc_width(MAX_NUMBER_DIGITS),
  localparam int VW    = atoc_pkg::VALUE_W,
  localparam int CNT_W = $clog2(ACC_W)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  atoc_pkg::launch_t   launch,
  input  logic [ACC_W-1:0]    first_opnd,
  input  logic [ACC_W-1:0]    second_opnd,
  input  logic                take,
  output logic                idle,
  output logic                done,
  output logic [VW-1:0]       res_value,
  output atoc_pkg::status_t   res_status
);

  atoc_pkg::alu_state_t state_r, state_nxt;
  logic [VW-1:0]        a_r, a_nxt;
  logic [VW-1:0]        b_r, b_nxt;
  logic [VW-1:0]        acc_r, acc_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  atoc_pkg::op_t        op_r, op_nxt;
  atoc_pkg::status_t    status_r, status_nxt;
  atoc_pkg::status_t    start_status;

  logic [VW-1:0]        add_x, add_y;
  logic                 add_sub;
  logic [VW:0]          sum;
  logic                 carry;

  always_comb begin
    priority if (launch.ovf) begin
      start_status = atoc_pkg::ST_OVERFLOW;
    end else if (!launch.op_seen) begin
      start_status = atoc_pkg::ST_NO_OPERATOR;
    end else if (launch.op == atoc_pkg::OP_DIV && second_opnd == '0) begin
      start_status = atoc_pkg::ST_DIV_ZERO;
    end else begin
      start_status = atoc_pkg::ST_OK;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      atoc_pkg::S_IDLE: begin
        if (start) begin
          if (start_status != atoc_pkg::ST_OK) begin
            state_nxt = atoc_pkg::S_DONE;
          end else begin
            unique case (launch.op)
              atoc_pkg::OP_ADD, atoc_pkg::OP_SUB: state_nxt = atoc_pkg::S_ADDSUB;
              atoc_pkg::OP_MUL:                   state_nxt = atoc_pkg::S_MUL;
              atoc_pkg::OP_DIV:                   state_nxt = atoc_pkg::S_DIV;
            endcase
          end
        end
      end
      atoc_pkg::S_ADDSUB: state_nxt = atoc_pkg::S_DONE;
      atoc_pkg::S_MUL, atoc_pkg::S_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = atoc_pkg::S_DONE;
        end
      end
      atoc_pkg::S_DONE: begin
        if (take) begin
          state_nxt = atoc_pkg::S_IDLE;
        end
      end
      default: state_nxt = atoc_pkg::S_IDLE;
    endcase
  end

  // shared adder operand selection
  always_comb begin
    add_x   = a_r;
    add_y   = b_r;
    add_sub = 1'b0;
    unique case (state_r)
      atoc_pkg::S_ADDSUB: add_sub = (op_r == atoc_pkg::OP_SUB);
      atoc_pkg::S_MUL: begin
        add_x = acc_r;
        add_y = a_r;
      end
      atoc_pkg::S_DIV: begin
        add_x   = {acc_r[VW-2:0], a_r[ACC_W-1]};
        add_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign sum   = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + (VW+1)'(add_sub);
  assign carry = sum[VW];

  // datapath and outputs
  always_comb begin
    a_nxt      = a_r;
    b_nxt      = b_r;
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    op_nxt     = op_r;
    status_nxt = status_r;
    unique case (state_r)
      atoc_pkg::S_IDLE: begin
        if (start) begin
          a_nxt      = VW'(first_opnd);
          b_nxt      = VW'(second_opnd);
          acc_nxt    = '0;
          cnt_nxt    = CNT_W'(ACC_W - 1);
          op_nxt     = launch.op;
          status_nxt = start_status;
        end
      end
      atoc_pkg::S_ADDSUB: acc_nxt = sum[VW-1:0];
      atoc_pkg::S_MUL: begin
        if (b_r[0]) begin
          acc_nxt = sum[VW-1:0];
        end
        a_nxt   = a_r << 1;
        b_nxt   = b_r >> 1;
        cnt_nxt = cnt_r - 1'b1;
      end
      atoc_pkg::S_DIV: begin
        // no borrow means the trial subtract fits
        acc_nxt = carry ? sum[VW-1:0] : add_x;
        a_nxt   = {a_r[VW-2:0], carry};
        cnt_nxt = cnt_r - 1'b1;
      end
      default: ;
    endcase
  end

  assign idle       = (state_r == atoc_pkg::S_IDLE);
  assign done       = (state_r == atoc_pkg::S_DONE);
  assign res_status = status_r;
  assign res_value  = (status_r != atoc_pkg::ST_OK) ? '0 :
                      (op_r == atoc_pkg::OP_DIV) ? VW'(a_r[ACC_W-1:0]) : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= atoc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    acc_r    <= acc_nxt;
    cnt_r    <= cnt_nxt;
    op_r     <= op_nxt;
    status_r <= status_nxt;
  end

  `ASSERT_IMPLY(a_start_when_idle, clk, rst_n, start, state_r == atoc_pkg::S_IDLE)
  `ASSERT_NEXT(a_ovf_short_path, clk, rst_n, start && launch.ovf, state_r == atoc_pkg::S_DONE && status_r == atoc_pkg::ST_OVERFLOW)

endmodule

@@ sv/ascii_two_operand_calculator_core.sv @@
// top level of the ascii two-operand calculator
// a non-final request is accepted back to back; a final one starts the unit, which goes straight
//   to done on an error status, through the add/subtract state on add or subtract, and through
//   one shift-add or divide step per cycle on the shared adder on multiply or divide
// the next request is taken once the unit is idle again; ready stays low while the unit
//   works or holds a finished result that the full output register cannot take; reset:
//   synchronous active-low rst_n clears parser state, sequencer and output valid
`include "assert_macros.svh"
module ascii_two_operand_calculator_core #(
  parameter int MAX_NUMBER_DIGITS = atoc_pkg::MAX_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  atoc_in_if.sink     in_ch,
  atoc_out_if.source  out_ch
);

  localparam int ACC_W = atoc_pkg::acc_width(MAX_NUMBER_DIGITS);
  localparam int VW    = atoc_pkg::VALUE_W;

  // request handshake on the character side
  logic                     in_fire;
  atoc_pkg::launch_t        launch;
  logic [ACC_W-1:0]         first_opnd;
  logic [ACC_W-1:0]         second_opnd;

  // arithmetic unit handshake
  logic                     alu_idle;
  logic                     alu_done;
  logic                     alu_take;
  logic [VW-1:0]            alu_value;
  atoc_pkg::status_t        alu_status;

  // output register parting the result side from the arithmetic unit
  logic                     out_valid_r, out_valid_nxt;
  logic [VW-1:0]            out_value_r;
  atoc_pkg::status_t        out_status_r;

  // input is taken whenever the unit is not busy with a final character
  assign in_ch.ready = alu_idle;
  assign in_fire     = in_ch.valid && in_ch.ready;

  atoc_parser #(
    .MAX_NUMBER_DIGITS (MAX_NUMBER_DIGITS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (in_fire),
    .char_byte   (in_ch.char_byte),
    .final_char  (in_ch.final_char),
    .launch      (launch),
    .first_opnd  (first_opnd),
    .second_opnd (second_opnd)
  );

  // the final character launches the arithmetic with the closed-out operands
  atoc_alu #(
    .MAX_NUMBER_DIGITS (MAX_NUMBER_DIGITS)
  ) u_alu (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_fire && in_ch.final_char),
    .launch      (launch),
    .first_opnd  (first_opnd),
    .second_opnd (second_opnd),
    .take        (alu_take),
    .idle        (alu_idle),
    .done        (alu_done),
    .res_value   (alu_value),
    .res_status  (alu_status)
  );

  // a finished result moves on when the output slot is empty or draining
  assign alu_take = alu_done && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (alu_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (alu_take) begin
      out_value_r  <= alu_value;
      out_status_r <= alu_status;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = out_value_r;
  assign out_ch.status = out_status_r;

  // a taken result is presented on the next cycle
  `ASSERT_NEXT(a_take_shows_result, clk, rst_n, alu_take, out_valid_r)
  // input is never open while a result sits in the arithmetic unit
  `ASSERT_IMPLY(a_ready_not_done, clk, rst_n, in_ch.ready, !alu_done)

endmodule
